@@ hdl/sobth_pkg.sv @@
// Shared constants and types for the Sobel edge threshold core.
`timescale 1ns / 1ps
`default_nettype none

package sobth_pkg;

   localparam int MaxWidth   = 2048;
   localparam int ColWidth   = $clog2(MaxWidth);
   localparam int PixWidth   = 8;
   localparam int RowWidth   = 16;
   localparam int ThrWidth   = 11;
   localparam int FwWidth    = 12;
   localparam int MagWidth   = 11;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 16;

   localparam logic [CsrIdxWidth-1:0] CsrEdgeThreshold = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrFrameWidth    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrFrameHeight   = 2'd2;

   localparam logic [ThrWidth-1:0] ThresholdReset = 11'd50;
   localparam logic [FwWidth-1:0]  WidthReset     = 12'd640;
   localparam logic [RowWidth-1:0] HeightReset    = 16'd480;

   // One completed 3x3 window, taken from the line buffer stage to the gradient stage.
   typedef struct packed {
      logic                valid;
      logic [PixWidth-1:0] t0;
      logic [PixWidth-1:0] t1;
      logic [PixWidth-1:0] top;
      logic [PixWidth-1:0] m0;
      logic [PixWidth-1:0] mid;
      logic [PixWidth-1:0] b0;
      logic [PixWidth-1:0] b1;
      logic [PixWidth-1:0] bot;
      logic [10:0]         center_col;
      logic [RowWidth-1:0] center_row;
      logic                last;
   } window_type;

endpackage

`default_nettype wire

@@ hdl/sobth_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sobth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/sobth_window.sv @@
// Line buffers, 3x3 window, raster counters and window register.
`timescale 1ns / 1ps
`default_nettype none

module sobth_window import sobth_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [PixWidth-1:0] pixel,
   input  wire logic [FwWidth-1:0]  frame_width,
   input  wire logic [RowWidth-1:0] frame_height,
   input  wire logic                advance,
   output window_type               win
);

   logic [ColWidth-1:0] col_ff, col_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic [PixWidth-1:0] shift_ff [6];
   window_type          win_ff, win_in;

   logic [FwWidth-1:0]  w_eff;
   logic [RowWidth-1:0] h_eff;
   logic                row_end, frame_end;
   logic [ColWidth-1:0] rd_addr;
   logic [2*PixWidth-1:0] rd_data;
   logic [PixWidth-1:0] top, mid;

   localparam logic [FwWidth-1:0] WidthMax = FwWidth'(MaxWidth);

   always_comb begin
      w_eff = frame_width;
      if (frame_width < FwWidth'(3)) w_eff = FwWidth'(3);
      if (frame_width > WidthMax) w_eff = WidthMax;
      h_eff = (frame_height < RowWidth'(3)) ? RowWidth'(3) : frame_height;
   end

   assign row_end   = ({1'b0, col_ff} + FwWidth'(1)) >= w_eff;
   assign frame_end = row_end && (({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff});

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + RowWidth'(1);
      end else begin
         col_in = col_ff + ColWidth'(1);
      end
   end

   // Look up the next column ahead so the buffer data is ready when the item arrives.
   assign rd_addr = accept ? col_in : col_ff;
   assign top = rd_data[2*PixWidth-1:PixWidth];
   assign mid = rd_data[PixWidth-1:0];

   sobth_ram #(
      .WIDTH(2*PixWidth),
      .DEPTH(MaxWidth)
   ) line_buf (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(col_ff),
      .wr_data({mid, pixel}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      win_in = win_ff;
      if (advance) begin
         win_in.valid = 1'b0;
      end
      if (accept) begin
         win_in.valid      = (row_ff >= RowWidth'(2)) && (col_ff >= ColWidth'(2));
         win_in.t0         = shift_ff[0];
         win_in.t1         = shift_ff[1];
         win_in.top        = top;
         win_in.m0         = shift_ff[2];
         win_in.mid        = mid;
         win_in.b0         = shift_ff[4];
         win_in.b1         = shift_ff[5];
         win_in.bot        = pixel;
         win_in.center_col = col_ff - ColWidth'(1);
         win_in.center_row = row_ff - RowWidth'(1);
         win_in.last       = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 6; i++) shift_ff[i] <= '0;
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
         if (accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            shift_ff[0] <= shift_ff[1];
            shift_ff[1] <= top;
            shift_ff[2] <= shift_ff[3];
            shift_ff[3] <= mid;
            shift_ff[4] <= shift_ff[5];
            shift_ff[5] <= pixel;
         end
      end
   end

   assign win = win_ff;

endmodule

`default_nettype wire

@@ hdl/sobth_grad.sv @@
// Sobel gradients, L1 magnitude, threshold compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module sobth_grad import sobth_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire window_type          win,
   input  wire logic [ThrWidth-1:0] edge_threshold,
   output logic                     advance,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_edge_res,
   output logic [MagWidth-1:0]      rsp_magnitude,
   output logic [10:0]              rsp_center_col,
   output logic [RowWidth-1:0]      rsp_center_row,
   output logic                     rsp_last
);

   logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
   logic [MagWidth-1:0] mag;

   logic                valid_ff;
   logic                edge_ff;
   logic [MagWidth-1:0] mag_ff;
   logic [10:0]         col_ff;
   logic [RowWidth-1:0] row_ff;
   logic                last_ff;

   always_comb begin
      gx_pos = 10'(win.b0) + {1'b0, win.b1, 1'b0} + 10'(win.bot);
      gx_neg = 10'(win.t0) + {1'b0, win.t1, 1'b0} + 10'(win.top);
      gy_pos = 10'(win.top) + {1'b0, win.mid, 1'b0} + 10'(win.bot);
      gy_neg = 10'(win.t0) + {1'b0, win.m0, 1'b0} + 10'(win.b0);
      gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      mag    = 11'(gx_abs) + 11'(gy_abs);
   end

   // Move the window item on whenever the result register is empty or being drained.
   assign advance = win.valid && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= win.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         edge_ff <= edge_threshold <= mag;
         mag_ff  <= mag;
         col_ff  <= win.center_col;
         row_ff  <= win.center_row;
         last_ff <= win.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_edge_res   = edge_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_center_col = col_ff;
   assign rsp_center_row = row_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

@@ hdl/sobel_edge_threshold_core.sv @@
// Top level of the streaming Sobel edge threshold core.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_pixel
//  rsp     | out       | rsp_valid / rsp_stall | rsp_edge_res, rsp_magnitude,
//          |           |                       | rsp_center_col, rsp_center_row, rsp_last
//  csr     | in        | csr_write             | csr_index, csr_data
//
// One pixel per clock unless stalled; results pass the window then the result register.
// The line buffer RAM read for the next column is issued on the accepting edge.
// Reset is synchronous: counters and window clear, the line buffer is not cleared.
// The input stalls only when both the window register and result register are full
// and the result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold_core import sobth_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [PixWidth-1:0]     req_pixel,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_edge_res,
   output logic [MagWidth-1:0]          rsp_magnitude,
   output logic [10:0]                  rsp_center_col,
   output logic [RowWidth-1:0]          rsp_center_row,
   output logic                         rsp_last,
   input  wire logic                    csr_write,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data
);

   logic [ThrWidth-1:0] threshold_ff;
   logic [FwWidth-1:0]  width_ff;
   logic [RowWidth-1:0] height_ff;
   window_type          win;
   logic                advance;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrEdgeThreshold: threshold_ff <= csr_data[ThrWidth-1:0];
            CsrFrameWidth:    width_ff     <= csr_data[FwWidth-1:0];
            CsrFrameHeight:   height_ff    <= csr_data[RowWidth-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = win.valid && !advance;
   assign accept    = req_valid && !req_stall;

   sobth_window window_stage (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_pixel),
      .frame_width (width_ff),
      .frame_height(height_ff),
      .advance     (advance),
      .win         (win)
   );

   sobth_grad grad_stage (
      .clock         (clock),
      .reset         (reset),
      .win           (win),
      .edge_threshold(threshold_ff),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_edge_res  (rsp_edge_res),
      .rsp_magnitude (rsp_magnitude),
      .rsp_center_col(rsp_center_col),
      .rsp_center_row(rsp_center_row),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
